@@ rtl/tccs_pkg.sv @@
// Shared types and constants for the text console cursor and scrollback engine.
// Used by tccs_divider and text_console_cursor_scroll; depends on nothing.
`default_nettype none

package tccs_pkg;

  // Divider geometry: a 17-bit dividend over an 8-bit divisor, one quotient bit a cycle.
  localparam int DIV_BITS  = 17;
  localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);
  localparam int DVS_W     = 8;

  // Command codes.
  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_NAV   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Control characters.
  localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [7:0] CHAR_TAB       = 8'd9;
  localparam logic [7:0] CHAR_NEWLINE   = 8'd10;

  // Navigation keys.
  localparam logic [3:0] KEY_HOME   = 4'd0;
  localparam logic [3:0] KEY_END    = 4'd1;
  localparam logic [3:0] KEY_PGUP   = 4'd2;
  localparam logic [3:0] KEY_PGDN   = 4'd3;
  localparam logic [3:0] KEY_UP     = 4'd4;
  localparam logic [3:0] KEY_DOWN   = 4'd5;
  localparam logic [3:0] KEY_RIGHT  = 4'd6;
  localparam logic [3:0] KEY_LEFT   = 4'd7;
  localparam logic [3:0] KEY_DELETE = 4'd8;

  // Configuration register indexes.
  localparam logic [1:0] REG_SCREEN_WIDTH = 2'd0;
  localparam logic [1:0] REG_TAB_WIDTH    = 2'd1;
  localparam logic [1:0] REG_SCREEN_CELLS = 2'd2;
  localparam logic [1:0] REG_TEXT_ATTR    = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [7:0]  RST_SCREEN_WIDTH = 8'd80;
  localparam logic [7:0]  RST_TAB_WIDTH    = 8'd8;
  localparam logic [15:0] RST_SCREEN_CELLS = 16'd2000;
  localparam logic [7:0]  RST_TEXT_ATTR    = 8'd7;

  typedef struct packed {
    logic                start;
    logic [DIV_BITS-1:0] dividend;
    logic [DVS_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [DIV_BITS-1:0] quotient;
    logic [DVS_W-1:0]    remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/tccs_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the console engine.
// Depends on tccs_pkg for its request and response structs.
`default_nettype none

module tccs_divider (
  input  wire                clk,
  input  wire                rst,
  input  wire tccs_pkg::div_req_t req,
  output tccs_pkg::div_rsp_t rsp
);
  import tccs_pkg::*;

  logic [DVS_W-1:0]     rem;
  logic [DIV_BITS-1:0]  quo;
  logic [DVS_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;

  logic [DVS_W:0]   trial;
  logic             fits;
  logic [DVS_W:0]   diff;

  // The trial remainder never reaches twice the divisor, so one subtract settles a bit.
  assign trial = {rem, quo[DIV_BITS-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      quo <= {quo[DIV_BITS-2:0], fits};
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

@@ rtl/text_console_cursor_scroll.sv @@
// Text console cursor and scrollback engine: top level with sequencer and state.
// Depends on tccs_pkg and the shared divider tccs_divider.
//
//   channel   signals                              direction
//   in        in_valid, in_stall, cmd..nav_key     item in, one beat per command
//   out       out_valid, out_stall, write_enable.. result out, one beat per item
//   cfg       cfg_write, cfg_index, cfg_data       register writes, no handshake
//
// Each item runs the divider for the cursor column and then for its row before
// the result is loaded; newline, tab, home and end first run it for the cursor
// modulo the screen width (the tab width for tab), before the step.
// Reset clears the cursor and view and loads the register defaults.
// A stalled result holds in the output register; the next item may already be
// accepted and waits for it only at its own end.
`default_nettype none

module text_console_cursor_scroll (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  cmd,
  input  wire  [7:0]  char_code,
  input  wire  [3:0]  nav_key,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        write_enable,
  output logic [16:0] write_address,
  output logic [15:0] write_data,
  output logic [15:0] cursor_offset,
  output logic [15:0] view_origin,
  output logic        redraw,
  output logic [7:0]  cursor_column,
  output logic [16:0] cursor_row,
  output logic        clear_all,
  input  wire         cfg_write,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_data
);
  import tccs_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PRE  = 6'b000010,
    S_STEP = 6'b000100,
    S_FIX  = 6'b001000,
    S_COL  = 6'b010000,
    S_ROW  = 6'b100000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [7:0]  screen_width;
  logic [7:0]  tab_width;
  logic [15:0] screen_cells;
  logic [7:0]  text_attribute;

  // Architectural state.
  logic [15:0] view_start;
  logic [15:0] cursor_pos;

  // Latched item and partial result.
  logic [1:0]  cmd_r;
  logic [7:0]  code_r;
  logic [3:0]  key_r;
  logic        we_r;
  logic [16:0] waddr_r;
  logic [15:0] wdata_r;
  logic        redraw_r;
  logic        clr_r;
  logic [7:0]  col_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        in_accept;
  logic        need_pre;
  logic [7:0]  w;
  logic [7:0]  tw;
  logic [15:0] w16;
  logic        out_free;

  tccs_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign w         = (screen_width == 8'd0) ? 8'd1 : screen_width;
  assign tw        = (tab_width == 8'd0) ? 8'd1 : tab_width;
  assign w16       = {8'd0, w};
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Newline, tab, home and end need the cursor modulo a width before the step.
  assign need_pre = ((cmd == CMD_PUT) && ((char_code == CHAR_NEWLINE) ||
                                          (char_code == CHAR_TAB))) ||
                    ((cmd == CMD_NAV) && ((nav_key == KEY_HOME) || (nav_key == KEY_END)));

  // ---------------- Step: apply the command ----------------
  logic [15:0] c1, vs1;
  logic        st_we, st_redraw, st_clr;
  logic [16:0] st_waddr;
  logic [15:0] st_wdata;
  logic [15:0] cp1, cm1, rem16;
  logic [7:0]  wdiff;

  assign cp1   = cursor_pos + 16'd1;
  assign cm1   = cursor_pos - 16'd1;
  assign rem16 = {8'd0, div_rsp.remainder};
  assign wdiff = ((code_r == CHAR_TAB) && (cmd_r == CMD_PUT) ? tw : w) - div_rsp.remainder;

  always_comb begin
    c1        = cursor_pos;
    vs1       = view_start;
    st_we     = 1'b0;
    st_waddr  = '0;
    st_wdata  = '0;
    st_redraw = 1'b0;
    st_clr    = 1'b0;
    unique case (cmd_r)
      CMD_PUT: begin
        st_redraw = 1'b1;
        if ((code_r == CHAR_NEWLINE) || (code_r == CHAR_TAB)) begin
          c1 = cursor_pos + {8'd0, wdiff};
        end else if (code_r == CHAR_BACKSPACE) begin
          if (cursor_pos != 16'd0) begin
            c1       = cm1;
            st_we    = 1'b1;
            st_waddr = {1'b0, view_start} + {1'b0, cm1};
            st_wdata = {text_attribute, 8'd0};
          end
        end else begin
          c1       = cp1;
          st_we    = 1'b1;
          st_waddr = {1'b0, view_start} + {1'b0, cursor_pos};
          st_wdata = {text_attribute, code_r};
        end
      end
      CMD_NAV: begin
        unique case (key_r)
          KEY_HOME: c1 = cursor_pos - rem16;
          KEY_END:  c1 = cursor_pos + {8'd0, wdiff} - 16'd1;
          KEY_PGUP: begin
            vs1       = view_start - screen_cells;
            st_redraw = 1'b1;
          end
          KEY_PGDN: begin
            vs1       = view_start + screen_cells;
            st_redraw = 1'b1;
          end
          KEY_UP: begin
            if (cursor_pos < w16) begin
              vs1       = view_start - w16;
              st_redraw = 1'b1;
            end else begin
              c1 = cursor_pos - w16;
            end
          end
          KEY_DOWN: begin
            // A width beyond the screen makes the signed bound negative.
            if ((screen_cells < w16) || (cursor_pos >= screen_cells - w16)) begin
              vs1       = view_start + w16;
              st_redraw = 1'b1;
            end else begin
              c1 = cursor_pos + w16;
            end
          end
          KEY_RIGHT: begin
            if (cp1 >= screen_cells) begin
              vs1       = view_start + w16;
              c1        = cp1 - w16;
              st_redraw = 1'b1;
            end else begin
              c1 = cp1;
            end
          end
          KEY_LEFT: begin
            if (cursor_pos == 16'd0) begin
              vs1       = view_start - w16;
              c1        = w16 - 16'd1;
              st_redraw = 1'b1;
            end else begin
              c1 = cm1;
            end
          end
          KEY_DELETE: begin
            c1        = cp1;
            st_we     = 1'b1;
            st_waddr  = {1'b0, view_start} + {1'b0, cursor_pos};
            st_wdata  = {text_attribute, 8'd0};
            st_redraw = 1'b1;
          end
          default: ;
        endcase
      end
      CMD_CLEAR: begin
        c1        = '0;
        vs1       = '0;
        st_redraw = 1'b1;
        st_clr    = 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------- Fix: scroll after a put, wrap check after navigation ----------------
  logic [15:0] c2, vs2, vs_scr, c_scr, nav_sum;
  logic        fx_redraw;

  assign vs_scr  = view_start + w16;
  assign c_scr   = cursor_pos - w16;
  assign nav_sum = view_start + screen_cells + w16;

  always_comb begin
    c2        = cursor_pos;
    vs2       = view_start;
    fx_redraw = redraw_r;
    if ((cmd_r == CMD_PUT) && (cursor_pos >= screen_cells)) begin
      c2  = c_scr;
      vs2 = ((vs_scr + c_scr) < vs_scr) ? 16'd0 : vs_scr;
    end else if ((cmd_r == CMD_NAV) && (key_r <= KEY_DELETE) && (nav_sum < view_start)) begin
      c2        = '0;
      vs2       = '0;
      fx_redraw = 1'b1;
    end
  end

  // ---------------- Divider requests ----------------
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {1'b0, cursor_pos};
    div_req.divisor  = w;
    unique case (state)
      S_IDLE: begin
        div_req.start   = in_accept && need_pre;
        div_req.divisor = ((cmd == CMD_PUT) && (char_code == CHAR_TAB)) ? tw : w;
      end
      S_FIX: begin
        div_req.start    = 1'b1;
        div_req.dividend = {1'b0, c2};
      end
      S_COL: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = {1'b0, view_start} + {1'b0, cursor_pos};
      end
      default: ;
    endcase
  end

  // ---------------- Sequencer ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_accept) state_next = need_pre ? S_PRE : S_STEP;
      S_PRE:  if (div_rsp.done) state_next = S_STEP;
      S_STEP: state_next = S_FIX;
      S_FIX:  state_next = S_COL;
      S_COL:  if (div_rsp.done) state_next = S_ROW;
      S_ROW:  if (div_rsp.done && out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // The row quotient stays in the divider while the result waits for a free slot.
  logic row_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      row_ready <= 1'b0;
    end else if (state == S_ROW && div_rsp.done && !out_free) begin
      row_ready <= 1'b1;
    end else if (state == S_ROW && row_ready && out_free) begin
      row_ready <= 1'b0;
    end
  end

  logic load_out;
  assign load_out = (state == S_ROW) && (div_rsp.done || row_ready) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      view_start     <= '0;
      cursor_pos     <= '0;
      out_valid      <= 1'b0;
      screen_width   <= RST_SCREEN_WIDTH;
      tab_width      <= RST_TAB_WIDTH;
      screen_cells   <= RST_SCREEN_CELLS;
      text_attribute <= RST_TEXT_ATTR;
    end else begin
      state <= (state == S_ROW && row_ready && out_free) ? S_IDLE : state_next;
      if (cfg_write) begin
        unique case (cfg_index)
          REG_SCREEN_WIDTH: screen_width   <= cfg_data[7:0];
          REG_TAB_WIDTH:    tab_width      <= cfg_data[7:0];
          REG_SCREEN_CELLS: screen_cells   <= cfg_data;
          REG_TEXT_ATTR:    text_attribute <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (state == S_STEP) begin
        cursor_pos <= c1;
        view_start <= vs1;
      end else if (state == S_FIX) begin
        cursor_pos <= c2;
        view_start <= vs2;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r  <= cmd;
      code_r <= char_code;
      key_r  <= nav_key;
    end
    if (state == S_STEP) begin
      we_r     <= st_we;
      waddr_r  <= st_waddr;
      wdata_r  <= st_wdata;
      redraw_r <= st_redraw;
      clr_r    <= st_clr;
    end
    if (state == S_FIX) begin
      redraw_r <= fx_redraw;
    end
    if ((state == S_COL) && div_rsp.done) begin
      col_r <= div_rsp.remainder;
    end
    if (load_out) begin
      write_enable  <= we_r;
      write_address <= waddr_r;
      write_data    <= wdata_r;
      cursor_offset <= cursor_pos;
      view_origin   <= view_start;
      redraw        <= redraw_r;
      cursor_column <= col_r;
      cursor_row    <= div_rsp.quotient;
      clear_all     <= clr_r;
    end
  end

  // ---------------- Assertions ----------------
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> in_stall)
    else $error("input not blocked after a beat was taken");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clear_all) |-> (cursor_offset == 16'd0 && view_origin == 16'd0 && redraw))
    else $error("clear result does not show a reset cursor and view");

  a_load_from_row: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_ROW))
    else $error("result loaded outside the row phase");

endmodule

`default_nettype wire
